// ===== design/http_chunked_body_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// http chunked body decoder assertion macros
// Concurrent checks clocked on aclk, muted while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define HCBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HCBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants of the http chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    // size line limits
    localparam int unsigned SIZE_DIGITS = 8;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned LINE_W      = 14;
    localparam int unsigned TRAIL_W     = 16;
    localparam int unsigned LEN_W       = 32;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX  = DIGIT_W'(SIZE_DIGITS);
    localparam logic [LINE_W-1:0]  LINE_LIMIT = 14'd8200;
    localparam logic [LINE_W-1:0]  LINE_SAT   = 14'h3FFF;
    localparam logic [TRAIL_W-1:0] TRAIL_RST  = 16'd8192;

    // character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HTAB  = 8'h09;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // result kinds
    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_DATA  = 3'd1,
        KIND_EXT   = 3'd2,
        KIND_CEND  = 3'd3,
        KIND_LAST  = 3'd4,
        KIND_DONE  = 3'd5
    } kind_t;

    // sticky status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD      = 2'd1,
        ST_TOO_BIG  = 2'd2
    } status_t;

    // one result beat
    typedef struct packed {
        kind_t            kind;
        logic [7:0]       out_byte;
        logic             last_of_chunk;
        logic [LEN_W-1:0] chunk_length;
        status_t          status;
    } res_t;

    localparam int unsigned M_TDATA_W = 48;

endpackage

// ===== design/http_chunked_body_decoder_core.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// A result beat is registered in the output register, or in the skid while that one is held, before m_tvalid.
// Throughput: one byte per cycle while s_tready is high; the decode state updates in the accept cycle.
// A two-entry output buffer (output register plus skid) keeps s_tready high
// while a single result waits; s_tready drops only while the skid is full.
// Reset (aresetn low, synchronous) clears decode state and buffer valid flags,
// and sets max_trailer_bytes to 8192.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_core_assert.svh"

module http_chunked_body_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: max_trailer_bytes
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_tuser,   // [0] restart
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] out_byte, [39:8] chunk_length, [41:40] status
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast    // last_of_chunk
);

    typedef enum logic [2:0] {
        PH_SIZE  = 3'd0,
        PH_EXT   = 3'd1,
        PH_DATA  = 3'd2,
        PH_DCR   = 3'd3,
        PH_DLF   = 3'd4,
        PH_TRAIL = 3'd5,
        PH_DONE  = 3'd6
    } phase_t;

    // decode state
    phase_t                            phase_reg, phase_next;
    logic [hcbd_pkg::LEN_W-1:0]        size_reg, size_next;
    logic [hcbd_pkg::LEN_W-1:0]        left_reg, left_next;
    logic [hcbd_pkg::DIGIT_W-1:0]      digits_reg, digits_next;
    logic [hcbd_pkg::LINE_W-1:0]       line_reg, line_next;
    logic [hcbd_pkg::TRAIL_W-1:0]      trail_reg, trail_next;
    logic                              saw_cr_reg, saw_cr_next;
    logic                              after_sp_reg, after_sp_next;
    logic                              colon_reg, colon_next;
    hcbd_pkg::status_t                 err_reg, err_next;
    logic [hcbd_pkg::TRAIL_W-1:0]      max_trail_reg;

    // output buffer
    logic                              m_valid_reg;
    hcbd_pkg::res_t                    m_res_reg;
    logic                              skid_valid_reg;
    hcbd_pkg::res_t                    skid_res_reg;

    hcbd_pkg::res_t                    res;
    logic                              s_acc;
    logic                              m_acc;
    logic [7:0]                        c;
    logic                              restart;
    logic [4:0]                        hex;
    logic                              blank;
    logic [hcbd_pkg::LINE_W-1:0]       line_inc;

    // hex digit decode: bit 4 marks a valid digit
    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            r = {1'b1, ch[3:0]};
        end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
            r = {1'b1, 4'(ch[2:0] + 3'd1) + 4'd8};
        end
        return r;
    endfunction

    assign s_tready = !skid_valid_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_valid_reg && m_tready;
    assign c        = s_tdata;
    assign restart  = s_tuser[0];
    assign hex      = hex_decode(c);
    assign blank    = (c == hcbd_pkg::CH_SP) || (c == hcbd_pkg::CH_HTAB);

    // per-byte decode
    always_comb begin
        // restart clears state before this byte is taken
        if (restart) begin
            phase_next    = PH_SIZE;
            size_next     = '0;
            left_next     = '0;
            digits_next   = '0;
            line_next     = '0;
            trail_next    = '0;
            saw_cr_next   = 1'b0;
            after_sp_next = 1'b0;
            colon_next    = 1'b0;
            err_next      = hcbd_pkg::ST_OK;
        end else begin
            phase_next    = phase_reg;
            size_next     = size_reg;
            left_next     = left_reg;
            digits_next   = digits_reg;
            line_next     = line_reg;
            trail_next    = trail_reg;
            saw_cr_next   = saw_cr_reg;
            after_sp_next = after_sp_reg;
            colon_next    = colon_reg;
            err_next      = err_reg;
        end
        line_inc          = line_next + 1'b1;
        res.kind          = hcbd_pkg::KIND_NONE;
        res.out_byte      = '0;
        res.last_of_chunk = 1'b0;
        res.chunk_length  = '0;

        if (err_next == hcbd_pkg::ST_OK) begin
            case (phase_next)
                PH_SIZE, PH_EXT: begin
                    if (saw_cr_next) begin
                        // line end
                        if (c != hcbd_pkg::CH_LF) begin
                            err_next = hcbd_pkg::ST_BAD;
                        end else begin
                            saw_cr_next   = 1'b0;
                            line_next     = '0;
                            digits_next   = '0;
                            after_sp_next = 1'b0;
                            colon_next    = 1'b0;
                            if (size_next == '0) begin
                                res.kind   = hcbd_pkg::KIND_LAST;
                                phase_next = PH_TRAIL;
                            end else begin
                                left_next  = size_next;
                                phase_next = PH_DATA;
                            end
                        end
                    end else if (c == hcbd_pkg::CH_CR) begin
                        if (digits_next == '0) err_next = hcbd_pkg::ST_BAD;
                        else saw_cr_next = 1'b1;
                    end else begin
                        line_next = line_inc;
                        if (line_inc > hcbd_pkg::LINE_LIMIT) begin
                            err_next = hcbd_pkg::ST_BAD;
                        end else if (phase_next == PH_EXT) begin
                            // extension bytes after leading blanks
                            if (!(after_sp_next && blank)) begin
                                after_sp_next    = 1'b0;
                                res.kind         = hcbd_pkg::KIND_EXT;
                                res.out_byte     = c;
                                res.chunk_length = size_next;
                            end
                        end else if (hex[4]) begin
                            if (after_sp_next || digits_next >= hcbd_pkg::DIGIT_MAX
                                || size_next[31:28] != 4'd0) begin
                                err_next = hcbd_pkg::ST_BAD;
                            end else begin
                                size_next   = {size_next[27:0], hex[3:0]};
                                digits_next = digits_next + 1'b1;
                            end
                        end else if (digits_next == '0) begin
                            err_next = hcbd_pkg::ST_BAD;
                        end else if (blank) begin
                            after_sp_next = 1'b1;
                        end else if (c == hcbd_pkg::CH_SEMI) begin
                            phase_next    = PH_EXT;
                            after_sp_next = 1'b1;
                        end else begin
                            err_next = hcbd_pkg::ST_BAD;
                        end
                    end
                end
                PH_DATA: begin
                    res.kind         = hcbd_pkg::KIND_DATA;
                    res.out_byte     = c;
                    res.chunk_length = size_next;
                    if (left_next <= 32'd1) begin
                        res.last_of_chunk = 1'b1;
                        left_next         = '0;
                        phase_next        = PH_DCR;
                    end else begin
                        left_next = left_next - 1'b1;
                    end
                end
                PH_DCR: begin
                    if (c == hcbd_pkg::CH_CR) phase_next = PH_DLF;
                    else err_next = hcbd_pkg::ST_BAD;
                end
                PH_DLF: begin
                    if (c == hcbd_pkg::CH_LF) begin
                        res.kind         = hcbd_pkg::KIND_CEND;
                        res.chunk_length = size_next;
                        size_next        = '0;
                        saw_cr_next      = 1'b0;
                        line_next        = '0;
                        digits_next      = '0;
                        after_sp_next    = 1'b0;
                        colon_next       = 1'b0;
                        phase_next       = PH_SIZE;
                    end else begin
                        err_next = hcbd_pkg::ST_BAD;
                    end
                end
                PH_TRAIL: begin
                    if (trail_next >= max_trail_reg) begin
                        err_next = hcbd_pkg::ST_TOO_BIG;
                    end else begin
                        trail_next = trail_next + 1'b1;
                        if (saw_cr_next) begin
                            if (c != hcbd_pkg::CH_LF) begin
                                err_next = hcbd_pkg::ST_BAD;
                            end else if (line_next != '0 && !colon_next) begin
                                err_next = hcbd_pkg::ST_BAD;
                            end else begin
                                // empty line ends the message
                                if (line_next == '0) begin
                                    res.kind   = hcbd_pkg::KIND_DONE;
                                    phase_next = PH_DONE;
                                end
                                saw_cr_next   = 1'b0;
                                line_next     = '0;
                                digits_next   = '0;
                                after_sp_next = 1'b0;
                                colon_next    = 1'b0;
                            end
                        end else if (c == hcbd_pkg::CH_CR) begin
                            saw_cr_next = 1'b1;
                        end else begin
                            if (c == hcbd_pkg::CH_COLON) colon_next = 1'b1;
                            if (line_next < hcbd_pkg::LINE_SAT) line_next = line_inc;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // an error hides the result fields
        if (err_next != hcbd_pkg::ST_OK) begin
            res.kind          = hcbd_pkg::KIND_NONE;
            res.out_byte      = '0;
            res.last_of_chunk = 1'b0;
            res.chunk_length  = '0;
        end
        res.status = err_next;
    end

    // decode state and configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SIZE;
            size_reg      <= '0;
            left_reg      <= '0;
            digits_reg    <= '0;
            line_reg      <= '0;
            trail_reg     <= '0;
            saw_cr_reg    <= 1'b0;
            after_sp_reg  <= 1'b0;
            colon_reg     <= 1'b0;
            err_reg       <= hcbd_pkg::ST_OK;
            max_trail_reg <= hcbd_pkg::TRAIL_RST;
        end else begin
            if (cfg_wr_en) max_trail_reg <= cfg_wr_data;
            if (s_acc) begin
                phase_reg    <= phase_next;
                size_reg     <= size_next;
                left_reg     <= left_next;
                digits_reg   <= digits_next;
                line_reg     <= line_next;
                trail_reg    <= trail_next;
                saw_cr_reg   <= saw_cr_next;
                after_sp_reg <= after_sp_next;
                colon_reg    <= colon_next;
                err_reg      <= err_next;
            end
        end
    end

    // output buffer valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_acc) begin
            m_valid_reg    <= skid_valid_reg || s_acc;
            skid_valid_reg <= 1'b0;
        end else if (s_acc) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output buffer payload
    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_acc) begin
            m_res_reg <= skid_valid_reg ? skid_res_reg : res;
        end else if (s_acc) begin
            skid_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_res_reg.status, m_res_reg.chunk_length, m_res_reg.out_byte};
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_res_reg.last_of_chunk;

    // checks
    `HCBD_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, m_valid_reg,
        "skid entry held while output register is empty")
    `HCBD_ASSERT_NEXT(a_err_sticky,
        err_reg != hcbd_pkg::ST_OK && !(s_acc && restart),
        err_reg == $past(err_reg), "error status changed without restart")
    `HCBD_ASSERT_NOW(a_err_hides_kind,
        m_valid_reg && m_res_reg.status != hcbd_pkg::ST_OK,
        m_res_reg.kind == hcbd_pkg::KIND_NONE, "result kind set under error status")
    `HCBD_ASSERT_NOW(a_last_is_data, m_valid_reg && m_res_reg.last_of_chunk,
        m_res_reg.kind == hcbd_pkg::KIND_DATA, "last_of_chunk on a non-data beat")

endmodule
